// ===== design/cp1252_to_utf8_xml_escaper_top_defines.svh =====
// Assertion macros for the CP1252/UTF-8 to XML-safe UTF-8 escaper.
// Included by the top level; depends on nothing else.
`ifndef CP1252_TO_UTF8_XML_ESCAPER_TOP_DEFINES_SVH
`define CP1252_TO_UTF8_XML_ESCAPER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C2U_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2u: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define C2U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2u: next-cycle check failed");

`endif

// ===== design/c2u_pkg.sv =====
// Shared types, constants and encoding functions for the escaper.
// No dependencies; every other design file but the defines header imports this package.
package c2u_pkg;

    localparam int C_CP_W    = 21;
    localparam int C_BYTE_W  = 8;
    localparam int C_MAX_BYTES = 5;
    localparam int C_IDX_W   = 3;

    localparam logic [C_CP_W-1:0] C_REPL      = 21'h00FFFD;
    localparam logic [C_CP_W-1:0] C_CP_MAX    = 21'h10FFFF;
    localparam logic [C_CP_W-1:0] C_SURR_LO   = 21'h00D800;
    localparam logic [C_CP_W-1:0] C_SURR_HI   = 21'h00DFFF;
    localparam logic [C_CP_W-1:0] C_LIM_1B    = 21'h000080;
    localparam logic [C_CP_W-1:0] C_LIM_2B    = 21'h000800;
    localparam logic [C_CP_W-1:0] C_LIM_3B    = 21'h010000;
    localparam logic [C_CP_W-1:0] C_CP_AMP    = 21'h000026;
    localparam logic [C_CP_W-1:0] C_CP_LT     = 21'h00003C;
    localparam logic [C_CP_W-1:0] C_CP_GT     = 21'h00003E;

    localparam logic [C_BYTE_W-1:0] C_LEAD2   = 8'hC0;
    localparam logic [C_BYTE_W-1:0] C_LEAD3   = 8'hE0;
    localparam logic [C_BYTE_W-1:0] C_LEAD4   = 8'hF0;
    localparam logic [C_BYTE_W-1:0] C_CONT    = 8'h80;

    // Windows-1252 code points for bytes 0x80-0x9F; undefined slots hold U+FFFD.
    localparam logic [15:0] C_WIN1252_HIGH [32] = '{
        16'h20AC, 16'hFFFD, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'hFFFD, 16'h017D, 16'hFFFD,
        16'hFFFD, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'hFFFD, 16'h017E, 16'h0178
    };

    // One decoded character: its output bytes, first byte in slot 0.
    typedef struct packed {
        logic [C_IDX_W-1:0]                    last_idx;
        logic [C_MAX_BYTES-1:0][C_BYTE_W-1:0]  bytes;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    // Escape or UTF-8 encode one code point.
    function automatic t_entry encode_cp(input logic [C_CP_W-1:0] cp_in);
        t_entry             e;
        logic [C_CP_W-1:0]  cp;
        e  = '0;
        cp = cp_in;
        if (cp == C_CP_AMP) begin
            e.bytes[0] = "&";
            e.bytes[1] = "a";
            e.bytes[2] = "m";
            e.bytes[3] = "p";
            e.bytes[4] = ";";
            e.last_idx = 3'd4;
        end else if (cp == C_CP_LT || cp == C_CP_GT) begin
            e.bytes[0] = "&";
            e.bytes[1] = (cp == C_CP_LT) ? 8'("l") : 8'("g");
            e.bytes[2] = "t";
            e.bytes[3] = ";";
            e.last_idx = 3'd3;
        end else begin
            if (cp == '0 || cp > C_CP_MAX || (cp >= C_SURR_LO && cp <= C_SURR_HI)) begin
                cp = C_REPL;
            end
            if (cp < C_LIM_1B) begin
                e.bytes[0] = cp[7:0];
                e.last_idx = 3'd0;
            end else if (cp < C_LIM_2B) begin
                e.bytes[0] = C_LEAD2 | {3'b000, cp[10:6]};
                e.bytes[1] = C_CONT  | {2'b00, cp[5:0]};
                e.last_idx = 3'd1;
            end else if (cp < C_LIM_3B) begin
                e.bytes[0] = C_LEAD3 | {4'b0000, cp[15:12]};
                e.bytes[1] = C_CONT  | {2'b00, cp[11:6]};
                e.bytes[2] = C_CONT  | {2'b00, cp[5:0]};
                e.last_idx = 3'd2;
            end else begin
                e.bytes[0] = C_LEAD4 | {5'b00000, cp[20:18]};
                e.bytes[1] = C_CONT  | {2'b00, cp[17:12]};
                e.bytes[2] = C_CONT  | {2'b00, cp[11:6]};
                e.bytes[3] = C_CONT  | {2'b00, cp[5:0]};
                e.last_idx = 3'd3;
            end
        end
        return e;
    endfunction

endpackage

// ===== design/c2u_if.sv =====
// Valid/ready channel interfaces for input items, output bytes and configuration.
// Depends on c2u_pkg for field widths.
interface c2u_in_if;
    import c2u_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [C_CP_W-1:0]    value;
    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface c2u_out_if;
    import c2u_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [C_BYTE_W-1:0]  out_byte;
    logic                 last;
    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface c2u_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/c2u_front.sv =====
// Front end: holds the source register, accepts items and turns each into its byte sequence.
// Depends on c2u_pkg and the channel interfaces.
module c2u_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    c2u_in_if.sink            i_in,
    c2u_cfg_if.sink           i_cfg,
    input  logic              i_full,
    output logic              o_push,
    output c2u_pkg::t_entry   o_entry
);
    import c2u_pkg::*;

    logic               r_source_is_utf8;
    logic [C_CP_W-1:0]  cp_sel;
    logic               raw_pass;
    t_entry             raw_entry;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign o_push      = i_in.valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_is_utf8 <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_source_is_utf8 <= i_cfg.data;
        end
    end

    always_comb begin
        cp_sel   = i_in.value;
        raw_pass = 1'b0;
        if (!i_in.action) begin
            if (!i_in.value[7] || i_in.value[7:5] != 3'b100) begin
                // ASCII, or Latin-1 range that maps to itself.
                cp_sel = {13'd0, i_in.value[7:0]};
            end else begin
                cp_sel = {5'd0, C_WIN1252_HIGH[i_in.value[4:0]]};
            end
            if (i_in.value[7] && r_source_is_utf8) begin
                raw_pass = 1'b1;
            end
        end
    end

    always_comb begin
        raw_entry          = '0;
        raw_entry.bytes[0] = i_in.value[7:0];
        raw_entry.last_idx = '0;
    end

    assign o_entry = raw_pass ? raw_entry : encode_cp(cp_sel);

endmodule

// ===== design/c2u_queue.sv =====
// Small FIFO of decoded entries between the front end and the back end.
// Depends on c2u_pkg.
module c2u_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  c2u_pkg::t_entry     i_push_entry,
    input  logic                i_pop,
    output c2u_pkg::t_entry     o_head,
    output c2u_pkg::t_q_status  o_status
);
    import c2u_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == CW'(DEPTH));

endmodule

// ===== design/c2u_back.sv =====
// Back end: walks the head entry one byte per cycle into the output register while the receiver is ready.
// Depends on c2u_pkg and the output channel interface.
module c2u_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  c2u_pkg::t_entry     i_head,
    input  c2u_pkg::t_q_status  i_status,
    output logic                o_pop,
    c2u_out_if.source           o_out
);
    import c2u_pkg::*;

    logic                 r_out_valid;
    logic [C_BYTE_W-1:0]  r_out_byte;
    logic                 r_out_last;
    logic [C_IDX_W-1:0]   r_idx, n_idx;
    logic                 advance;
    logic                 is_last;

    assign advance = i_status.valid && (!r_out_valid || o_out.ready);
    assign is_last = (r_idx == i_head.last_idx);
    assign o_pop   = advance && is_last;

    always_comb begin
        n_idx = r_idx;
        if (advance) begin
            n_idx = is_last ? '0 : r_idx + C_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_idx <= n_idx;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= i_head.bytes[r_idx];
            r_out_last <= is_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

endmodule

// ===== design/cp1252_to_utf8_xml_escaper_top.sv =====
// Top level of the Windows-1252 / UTF-8 to XML-safe UTF-8 escaper.
// Depends on c2u_pkg, the channel interfaces, c2u_front, c2u_queue, c2u_back and the defines header.
//
// Usage:
// Each input item on i_in is either a raw text byte (action 0) or a Unicode code point
// (action 1). The block writes the character as UTF-8 on o_out, one byte per item there,
// with last set on the final byte. '&', '<' and '>' come out as "&amp;", "&lt;", "&gt;";
// code point 0, surrogates, values beyond U+10FFFF and undefined Windows-1252 slots come
// out as U+FFFD. i_cfg writes source_is_utf8; it is always ready and should be written
// only while no item is in flight.
// The first byte of an item reaches o_out through the queue and then the output byte register.
// Throughput: the front end takes one item per cycle while the queue has room; the back
// end drives one output byte per cycle while the receiver is ready, so a multi-byte item
// holds the output until its last byte is taken. The single output byte register sets the sustained rate.
// Reset clears source_is_utf8 (Windows-1252 decoding), empties the queue and drops
// o_out.valid. When the receiver stalls, the output byte holds, the queue fills, and
// i_in.ready falls once QUEUE_DEPTH items are waiting.
`include "cp1252_to_utf8_xml_escaper_top_defines.svh"

module cp1252_to_utf8_xml_escaper_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    c2u_in_if.sink    i_in,
    c2u_cfg_if.sink   i_cfg,
    c2u_out_if.source o_out
);
    import c2u_pkg::*;

    t_entry     push_entry;
    t_entry     head_entry;
    t_q_status  q_status;
    logic       push;
    logic       pop;

    // Front end decodes the item into its full byte sequence in the cycle it arrives.
    c2u_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (q_status.full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // The queue decouples item intake from the slower byte-by-byte output.
    c2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_head       (head_entry),
        .o_status     (q_status)
    );

    // Back end serializes the head entry and retires it on its last byte.
    c2u_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_entry),
        .i_status (q_status),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    // An accepted item is waiting in the queue on the next cycle.
    `C2U_ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, i_in.valid && i_in.ready, q_status.valid)
    // Entries are only retired from a non-empty queue.
    `C2U_ASSERT_SAME(a_pop_nonempty, i_clk, i_rst_n, pop, q_status.valid)
    // Retiring an entry always presents its final byte.
    `C2U_ASSERT_NEXT(a_pop_last, i_clk, i_rst_n, pop, o_out.valid && o_out.last)
    // Queued work with a free output register is never left idle.
    `C2U_ASSERT_NEXT(a_no_bubble, i_clk, i_rst_n,
        q_status.valid && (!o_out.valid || o_out.ready), o_out.valid)

endmodule
